### design/gce_pkg.sv
// Shared types and constants for the greedy coloring extension block.
// No dependencies; used by greedy_coloring_extension.
package gce_pkg;

   // Vertex count default and fixed field widths
   localparam int DEF_VERTICES = 64;
   localparam int VERTEX_W     = 6;
   localparam int COLOR_W      = 6;
   localparam int USED_W       = 7;
   localparam int COLORS       = 64;
   localparam int ROW_W        = 64;
   localparam int GROUP_W      = 8;

   // Item function codes
   typedef enum logic [1:0] {
      FUNC_LOAD_ROW  = 2'd0,
      FUNC_SET_COLOR = 2'd1,
      FUNC_COLOR     = 2'd2,
      FUNC_CLEAR     = 2'd3
   } func_type;

   // Coloring sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW,
      ST_SCAN,
      ST_PICK_GROUP,
      ST_PICK_FINAL
   } state_type;

endpackage

### design/greedy_coloring_extension.sv
// First-fit coloring extension: adjacency and color stores plus a scan sequencer.
// Depends on gce_pkg.
//
// Load-row, set-color, clear items and items whose vertex is out of range are answered
// directly: the item's result is registered at the edge that accepts it. A color
// item first reads the adjacency row, then reads the color memory one vertex per
// cycle over all VERTICES vertices (its single read port sets this rate), then the
// group and final pick states choose the lowest free color over groups of eight;
// the final pick waits for a free output register. The block takes one item at a time
// and is ready again once the output register is empty or its result is being taken.
// The adjacency and color memories need no clearing pass after reset.
module greedy_coloring_extension #(
   parameter int VERTICES = gce_pkg::DEF_VERTICES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic [gce_pkg::VERTEX_W-1:0]  req_vertex,
   input  logic [gce_pkg::ROW_W-1:0]     req_adjacency_row,
   input  logic [gce_pkg::COLOR_W-1:0]   req_given_color,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gce_pkg::COLOR_W-1:0]   rsp_assigned_color,
   output logic [gce_pkg::USED_W-1:0]    rsp_colors_used
);

   localparam int ADDR_W = $clog2(VERTICES);
   localparam int CW     = gce_pkg::COLOR_W;
   localparam int GW     = gce_pkg::GROUP_W;
   localparam int NGRP   = (VERTICES + GW - 1) / GW;
   localparam int GIW    = $clog2(GW);

   // Memories
   logic [VERTICES-1:0] adj_mem [VERTICES];
   logic [CW-1:0]       color_mem [VERTICES];

   logic                adj_we;
   logic [ADDR_W-1:0]   adj_addr;
   logic [VERTICES-1:0] adj_rd_ff;
   logic                color_we;
   logic [ADDR_W-1:0]   color_waddr;
   logic [CW-1:0]       color_wdata;
   logic [ADDR_W-1:0]   color_raddr;
   logic [CW-1:0]       color_rd_ff;

   // Control and datapath registers
   gce_pkg::state_type      state_ff, state_in;
   logic [ADDR_W-1:0]       vtx_ff, vtx_in;
   logic [VERTICES-1:0]     nb_ff, nb_in;
   logic [gce_pkg::COLORS-1:0] used_ff, used_in;
   logic [ADDR_W:0]         cnt_ff, cnt_in;
   logic [ADDR_W-1:0]       tag_ff, tag_in;
   logic [NGRP-1:0]         grp_any_ff, grp_any_in;
   logic [GIW-1:0]          grp_idx_ff [NGRP];
   logic [GIW-1:0]          grp_idx_in [NGRP];
   logic [VERTICES-1:0]     mask_ff, mask_in;
   logic [CW-1:0]           max_ff, max_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]           rsp_color_ff, rsp_color_in;
   logic [gce_pkg::USED_W-1:0] rsp_used_ff, rsp_used_in;

   // Helpers
   logic                    accept;
   logic                    out_free;
   logic                    vtx_ok;
   logic [ADDR_W-1:0]       req_addr;
   logic [CW-1:0]           new_max;
   logic [NGRP*GW-1:0]      free_pad;
   logic [CW-1:0]           pick_color;
   logic [CW-1:0]           pick_max;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == gce_pkg::ST_IDLE) && out_free;
   assign accept   = req_valid && req_ready;
   assign vtx_ok   = int'(req_vertex) < VERTICES;
   assign req_addr = req_vertex[ADDR_W-1:0];
   assign new_max  = (req_given_color > max_ff) ? req_given_color : max_ff;

   // Adjacency memory: write on load, read the requested row every cycle
   assign adj_addr = req_addr;
   assign adj_we   = accept && vtx_ok && (req_func == gce_pkg::FUNC_LOAD_ROW);

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_addr] <= req_adjacency_row[VERTICES-1:0];
      end
      adj_rd_ff <= adj_mem[adj_addr];
   end

   // Color memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (color_we) begin
         color_mem[color_waddr] <= color_wdata;
      end
      color_rd_ff <= color_mem[color_raddr];
   end

   // Free-color groups: lowest free color within each group of eight
   always_comb begin
      free_pad = '0;
      free_pad[VERTICES-1:0] = ~used_ff[VERTICES-1:0];
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g] = 1'b0;
         grp_idx_in[g] = '0;
         for (int b = GW - 1; b >= 0; b--) begin
            if (free_pad[g*GW + b]) begin
               grp_any_in[g] = 1'b1;
               grp_idx_in[g] = GIW'(b);
            end
         end
      end
   end

   // Final pick over groups; saturate when nothing is free
   always_comb begin
      pick_color = CW'(VERTICES - 1);
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            pick_color = CW'(g * GW) + CW'(grp_idx_ff[g]);
         end
      end
      pick_max = (pick_color > max_ff) ? pick_color : max_ff;
   end

   // Sequencer: next state, datapath updates, memory controls
   always_comb begin
      state_in     = state_ff;
      vtx_in       = vtx_ff;
      nb_in        = nb_ff;
      used_in      = used_ff;
      cnt_in       = cnt_ff;
      tag_in       = tag_ff;
      mask_in      = mask_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_color_in = rsp_color_ff;
      rsp_used_in  = rsp_used_ff;
      color_we     = 1'b0;
      color_waddr  = req_addr;
      color_wdata  = req_given_color;
      color_raddr  = '0;

      case (state_ff)
         gce_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = '0;
               rsp_used_in  = {1'b0, max_ff} + 7'd1;
               case (gce_pkg::func_type'(req_func))
                  gce_pkg::FUNC_LOAD_ROW: begin
                     // row write happens in the memory block
                  end
                  gce_pkg::FUNC_SET_COLOR: begin
                     if (vtx_ok) begin
                        color_we          = 1'b1;
                        mask_in[req_addr] = 1'b1;
                        max_in            = new_max;
                        rsp_color_in      = req_given_color;
                        rsp_used_in       = {1'b0, new_max} + 7'd1;
                     end
                  end
                  gce_pkg::FUNC_COLOR: begin
                     // hold the response until the scan finishes
                     if (vtx_ok) begin
                        rsp_valid_in = 1'b0;
                        vtx_in       = req_addr;
                        state_in     = gce_pkg::ST_ROW;
                     end
                  end
                  gce_pkg::FUNC_CLEAR: begin
                     mask_in     = '0;
                     max_in      = '0;
                     rsp_used_in = 7'd1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         gce_pkg::ST_ROW: begin
            // latch colored neighbors, start reading colors at vertex zero
            nb_in       = adj_rd_ff & mask_ff;
            used_in     = '0;
            color_raddr = '0;
            tag_in      = '0;
            cnt_in      = (ADDR_W+1)'(1);
            state_in    = gce_pkg::ST_SCAN;
         end
         gce_pkg::ST_SCAN: begin
            // fold in the color read last cycle, issue the next read
            if (nb_ff[tag_ff]) begin
               used_in[color_rd_ff] = 1'b1;
            end
            if (int'(cnt_ff) < VERTICES) begin
               color_raddr = cnt_ff[ADDR_W-1:0];
            end
            tag_in = cnt_ff[ADDR_W-1:0];
            cnt_in = cnt_ff + (ADDR_W+1)'(1);
            if (int'(tag_ff) == VERTICES - 1) begin
               state_in = gce_pkg::ST_PICK_GROUP;
            end
         end
         gce_pkg::ST_PICK_GROUP: begin
            state_in = gce_pkg::ST_PICK_FINAL;
         end
         gce_pkg::ST_PICK_FINAL: begin
            // commit color and answer once the output register is free
            if (out_free) begin
               color_we        = 1'b1;
               color_waddr     = vtx_ff;
               color_wdata     = pick_color;
               mask_in[vtx_ff] = 1'b1;
               max_in          = pick_max;
               rsp_valid_in    = 1'b1;
               rsp_color_in    = pick_color;
               rsp_used_in     = {1'b0, pick_max} + 7'd1;
               state_in        = gce_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gce_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gce_pkg::ST_IDLE;
         mask_ff      <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      vtx_ff       <= vtx_in;
      nb_ff        <= nb_in;
      used_ff      <= used_in;
      cnt_ff       <= cnt_in;
      tag_ff       <= tag_in;
      grp_any_ff   <= grp_any_in;
      grp_idx_ff   <= grp_idx_in;
      rsp_color_ff <= rsp_color_in;
      rsp_used_ff  <= rsp_used_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_assigned_color = rsp_color_ff;
   assign rsp_colors_used    = rsp_used_ff;

   // Assertions
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == gce_pkg::ST_SCAN |-> int'(cnt_ff) <= VERTICES)
      else $error("scan counter past vertex count");

   a_color_start: assert property (@(posedge clock) disable iff (reset)
      (accept && vtx_ok && req_func == gce_pkg::FUNC_COLOR) |=>
         (state_ff == gce_pkg::ST_ROW && !rsp_valid_ff))
      else $error("color item did not start a scan");

   a_rsp_below_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_color_ff} < rsp_used_ff))
      else $error("answered color not below colors in use");

   a_commit_mask: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gce_pkg::ST_PICK_FINAL && out_free) |=>
         (mask_ff[$past(vtx_ff)] && rsp_valid_ff && state_ff == gce_pkg::ST_IDLE))
      else $error("colored vertex not marked on commit");

endmodule
